// ----- rtl/core/cfr_pkg.sv -----
package cfr_pkg;

  // Chunk buffer geometry
  localparam int unsigned CHUNK_BYTES = 256;
  localparam int unsigned CHUNK_WORDS = (CHUNK_BYTES + 3) / 4;
  localparam int unsigned WADDR_W     = (CHUNK_WORDS > 1) ? $clog2(CHUNK_WORDS) : 1;

  // Chunk length / fill counters and byte offsets within a chunk
  localparam int unsigned LEN_W = 9;
  localparam int unsigned OFF_W = LEN_W + 1;

  localparam logic [LEN_W-1:0] CHUNK_LEN = LEN_W'(CHUNK_BYTES);

  // CRC-32, reflected
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [15:0] TIMEOUT_RST = 16'd10000;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_A  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_FLASH = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    EV_READY         = 4'd0,
    EV_SIZE_TIMEOUT  = 4'd1,
    EV_RECEIVING     = 4'd2,
    EV_ERASE_REQ     = 4'd3,
    EV_ERASED        = 4'd4,
    EV_CHUNK_TIMEOUT = 4'd5,
    EV_CRC_TIMEOUT   = 4'd6,
    EV_NACK          = 4'd7,
    EV_FLASH_WORD    = 4'd8,
    EV_FLASH_FAIL    = 4'd9,
    EV_ACK           = 4'd10,
    EV_DONE          = 4'd11
  } event_e;

  // Controller -> datapath
  typedef struct packed {
    logic   capture;
    logic   start;
    logic   size_byte;
    logic   data_byte;
    logic   crc_byte;
    logic   tick;
    logic   flash_ack;
    logic   begin_chunk;
    logic   word_reset;
    logic   push;
    event_e ev;
    logic   last;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    cmd_e cmd;
    logic ok;
    logic hdr_last;
    logic size_zero;
    logic fill_last;
    logic crc_match;
    logic timeout;
    logic all_done;
    logic word_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- rtl/core/cfr_if.sv -----
// Input item channel
interface cfr_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;
  logic       flash_ok;

  modport source (output valid, output command, output rx_byte, output flash_ok,
                  input ready);
  modport sink   (input valid, input command, input rx_byte, input flash_ok,
                  output ready);
endinterface

// Result channel
interface cfr_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [31:0] flash_address;
  logic [31:0] flash_word;
  logic [31:0] image_size;
  logic        erase_slot;
  logic        last;

  modport source (output valid, output event_res, output flash_address,
                  output flash_word, output image_size, output erase_slot,
                  output last, input ready);
  modport sink   (input valid, input event_res, input flash_address,
                  input flash_word, input image_size, input erase_slot,
                  input last, output ready);
endinterface

// Configuration write channel
interface cfr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cfr_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/cfr_ram.sv -----
// Simple dual-port RAM, registered read
module cfr_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/cfr_dp.sv -----
// Datapath: session counters, CRC, chunk buffer, config and result register
module cfr_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfr_pkg::dp_cmd_t    cmd_i,
  output cfr_pkg::dp_sts_t    sts_o,
  input  logic [1:0]          command_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                flash_ok_i,
  cfr_cfg_if.sink             cfg_i,
  cfr_result_if.source        result_o
);

  localparam int unsigned LW = cfr_pkg::LEN_W;
  localparam int unsigned OW = cfr_pkg::OFF_W;
  localparam int unsigned AW = cfr_pkg::WADDR_W;

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ cfr_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Configuration registers
  logic [31:0] target_q, slot_a_q;
  logic [15:0] timeout_q;

  // Latched transaction
  cfr_pkg::cmd_e cmd_q;
  logic [7:0]    byte_q;
  logic          ok_q;

  // Session state
  logic [31:0] size_q, size_d;
  logic [1:0]  hdr_q, hdr_d;
  logic [31:0] bytes_q, bytes_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] fill_q, fill_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] rcv_q, rcv_d;
  logic [31:0] wp_q, wp_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [AW-1:0] widx_q, widx_d;

  // Result register
  logic        out_valid_q;
  logic [3:0]  out_ev_q;
  logic [31:0] out_addr_q, out_word_q, out_size_q;
  logic        out_slot_q, out_last_q;

  logic [31:0]   byte_sh;
  logic [LW-1:0] fill_inc;
  logic [15:0]   elapsed_inc;
  logic [31:0]   rem;
  logic [OW-1:0] off;
  logic [31:0]   word;
  logic [7:0]    bank_rdata [4];
  logic          out_free;
  logic          word_push;

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      slot_a_q  <= '0;
      timeout_q <= cfr_pkg::TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        cfr_pkg::REG_TARGET:  target_q  <= cfg_i.data;
        cfr_pkg::REG_SLOT_A:  slot_a_q  <= cfg_i.data;
        cfr_pkg::REG_TIMEOUT: timeout_q <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // Transaction capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= cfr_pkg::cmd_e'(command_i);
      byte_q <= rx_byte_i;
      ok_q   <= flash_ok_i;
    end
  end

  // Status terms
  assign byte_sh     = {24'd0, byte_q} << {hdr_q, 3'b000};
  assign fill_inc    = fill_q + LW'(1);
  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
  assign rem         = size_q - bytes_q;
  assign off         = OW'({widx_q, 2'b00});
  assign out_free    = !out_valid_q || result_o.ready;
  assign word_push   = cmd_i.push && (cmd_i.ev == cfr_pkg::EV_FLASH_WORD);

  always_comb begin
    sts_o.cmd       = cmd_q;
    sts_o.ok        = ok_q;
    sts_o.hdr_last  = (hdr_q == 2'd3);
    sts_o.size_zero = ((size_q | byte_sh) == 32'd0);
    sts_o.fill_last = (fill_inc >= len_q);
    sts_o.crc_match = (~crc_q == (rcv_q | byte_sh));
    sts_o.timeout   = (elapsed_inc >= timeout_q);
    sts_o.all_done  = ((bytes_q + 32'(len_q)) >= size_q);
    sts_o.word_last = ((off + OW'(4)) >= OW'(len_q));
    sts_o.out_free  = out_free;
  end

  // Session state update
  always_comb begin
    size_d    = size_q;
    hdr_d     = hdr_q;
    bytes_d   = bytes_q;
    len_d     = len_q;
    fill_d    = fill_q;
    crc_d     = crc_q;
    rcv_d     = rcv_q;
    wp_d      = wp_q;
    elapsed_d = elapsed_q;
    if (cmd_i.start) begin
      size_d    = '0;
      hdr_d     = '0;
      bytes_d   = '0;
      len_d     = '0;
      fill_d    = '0;
      crc_d     = cfr_pkg::CRC_INIT;
      rcv_d     = '0;
      wp_d      = target_q;
      elapsed_d = '0;
    end else if (cmd_i.size_byte) begin
      size_d = size_q | byte_sh;
      hdr_d  = hdr_q + 2'd1;
    end else if (cmd_i.data_byte) begin
      crc_d  = crc_step(crc_q, byte_q);
      fill_d = fill_inc;
      if (sts_o.fill_last) begin
        hdr_d     = '0;
        rcv_d     = '0;
        elapsed_d = '0;
      end
    end else if (cmd_i.crc_byte) begin
      rcv_d = rcv_q | byte_sh;
      hdr_d = hdr_q + 2'd1;
    end else if (cmd_i.tick) begin
      elapsed_d = elapsed_inc;
    end else if (cmd_i.flash_ack) begin
      wp_d    = wp_q + 32'(len_q);
      bytes_d = bytes_q + 32'(len_q);
    end else if (cmd_i.begin_chunk) begin
      len_d     = (rem > 32'(cfr_pkg::CHUNK_LEN)) ? cfr_pkg::CHUNK_LEN : rem[LW-1:0];
      fill_d    = '0;
      crc_d     = cfr_pkg::CRC_INIT;
      elapsed_d = '0;
    end
  end

  // Word walk index; RAM reads at the next index so data lines up
  always_comb begin
    widx_d = widx_q;
    if (cmd_i.word_reset) begin
      widx_d = '0;
    end else if (word_push) begin
      widx_d = widx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= '0;
      hdr_q     <= '0;
      bytes_q   <= '0;
      len_q     <= '0;
      fill_q    <= '0;
      crc_q     <= cfr_pkg::CRC_INIT;
      rcv_q     <= '0;
      wp_q      <= '0;
      elapsed_q <= '0;
      widx_q    <= '0;
    end else begin
      size_q    <= size_d;
      hdr_q     <= hdr_d;
      bytes_q   <= bytes_d;
      len_q     <= len_d;
      fill_q    <= fill_d;
      crc_q     <= crc_d;
      rcv_q     <= rcv_d;
      wp_q      <= wp_d;
      elapsed_q <= elapsed_d;
      widx_q    <= widx_d;
    end
  end

  // Chunk buffer: four byte lanes, one flash word per address
  for (genvar k = 0; k < 4; k++) begin : g_bank
    cfr_ram #(
      .Width (8),
      .Depth (cfr_pkg::CHUNK_WORDS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (cmd_i.data_byte && (fill_q[1:0] == 2'(k))),
      .waddr_i (fill_q[AW+1:2]),
      .wdata_i (byte_q),
      .raddr_i (widx_d),
      .rdata_o (bank_rdata[k])
    );
  end

  // Flash word assembly, pad bytes past the chunk end are 0xFF
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      word[8*k +: 8] = ((off + OW'(k)) < OW'(len_q)) ? bank_rdata[k] : 8'hFF;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.push || (out_valid_q && !result_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_ev_q   <= cmd_i.ev;
      out_last_q <= cmd_i.last;
      out_addr_q <= word_push ? (wp_q + 32'(off)) : 32'd0;
      out_word_q <= word_push ? word : 32'd0;
      out_size_q <= (cmd_i.ev == cfr_pkg::EV_RECEIVING) ? size_q : 32'd0;
      out_slot_q <= (cmd_i.ev == cfr_pkg::EV_ERASE_REQ) ? (target_q != slot_a_q) : 1'b0;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.event_res     = out_ev_q;
  assign result_o.flash_address = out_addr_q;
  assign result_o.flash_word    = out_word_q;
  assign result_o.image_size    = out_size_q;
  assign result_o.erase_slot    = out_slot_q;
  assign result_o.last          = out_last_q;

  // Checks
  a_fill_in_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= len_q)
    else $error("chunk fill ran past chunk length");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> out_free)
    else $error("result pushed over an untaken result");

  a_word_in_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_push |-> (off < OW'(len_q)))
    else $error("flash word emitted past chunk end");

endmodule

// ----- rtl/core/cfr_ctrl.sv -----
// Controller: session phase and transaction/result sequencing
module cfr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cfr_pkg::dp_sts_t sts_i,
  output cfr_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_EXEC   = 9'b000000010,
    S_ONE    = 9'b000000100,
    S_RECV   = 9'b000001000,
    S_ERASE  = 9'b000010000,
    S_ERASED = 9'b000100000,
    S_ACK    = 9'b001000000,
    S_DONE   = 9'b010000000,
    S_WORD   = 9'b100000000
  } state_e;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_SIZE  = 5'b00010,
    PH_DATA  = 5'b00100,
    PH_CRC   = 5'b01000,
    PH_FLASH = 5'b10000
  } phase_e;

  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  cfr_pkg::event_e ev_q, ev_d;
  logic            done_q, done_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    ev_d    = ev_q;
    done_d  = done_q;
    cmd_o   = '0;
    cmd_o.ev = ev_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end

      // Apply one transaction, pick the result sequence
      S_EXEC: begin
        state_d = S_IDLE;
        unique case (sts_i.cmd)
          cfr_pkg::CMD_START: begin
            cmd_o.start = 1'b1;
            phase_d     = PH_SIZE;
            ev_d        = cfr_pkg::EV_READY;
            state_d     = S_ONE;
          end
          cfr_pkg::CMD_BYTE: begin
            if (phase_q == PH_SIZE) begin
              cmd_o.size_byte = 1'b1;
              if (sts_i.hdr_last) begin
                done_d  = sts_i.size_zero;
                phase_d = sts_i.size_zero ? PH_IDLE : PH_DATA;
                state_d = S_RECV;
              end
            end else if (phase_q == PH_DATA) begin
              cmd_o.data_byte = 1'b1;
              if (sts_i.fill_last) begin
                phase_d = PH_CRC;
              end
            end else if (phase_q == PH_CRC) begin
              cmd_o.crc_byte = 1'b1;
              if (sts_i.hdr_last) begin
                if (sts_i.crc_match) begin
                  cmd_o.word_reset = 1'b1;
                  phase_d          = PH_FLASH;
                  state_d          = S_WORD;
                end else begin
                  ev_d    = cfr_pkg::EV_NACK;
                  phase_d = PH_IDLE;
                  state_d = S_ONE;
                end
              end
            end
          end
          cfr_pkg::CMD_TICK: begin
            if (phase_q == PH_SIZE || phase_q == PH_DATA || phase_q == PH_CRC) begin
              cmd_o.tick = 1'b1;
              if (sts_i.timeout) begin
                if (phase_q == PH_SIZE) begin
                  ev_d = cfr_pkg::EV_SIZE_TIMEOUT;
                end else if (phase_q == PH_DATA) begin
                  ev_d = cfr_pkg::EV_CHUNK_TIMEOUT;
                end else begin
                  ev_d = cfr_pkg::EV_CRC_TIMEOUT;
                end
                phase_d = PH_IDLE;
                state_d = S_ONE;
              end
            end
          end
          cfr_pkg::CMD_FLASH: begin
            if (phase_q == PH_FLASH) begin
              if (!sts_i.ok) begin
                ev_d    = cfr_pkg::EV_FLASH_FAIL;
                phase_d = PH_IDLE;
                state_d = S_ONE;
              end else begin
                cmd_o.flash_ack = 1'b1;
                done_d  = sts_i.all_done;
                phase_d = sts_i.all_done ? PH_IDLE : PH_DATA;
                state_d = S_ACK;
              end
            end
          end
          default: ;
        endcase
      end

      S_ONE: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.ev   = ev_q;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end

      // Size header done: report, request erase, report erased, then done if size is zero
      S_RECV: begin
        if (sts_i.out_free) begin
          cmd_o.push        = 1'b1;
          cmd_o.ev          = cfr_pkg::EV_RECEIVING;
          cmd_o.begin_chunk = !done_q;
          state_d           = S_ERASE;
        end
      end

      S_ERASE: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.ev   = cfr_pkg::EV_ERASE_REQ;
          state_d    = S_ERASED;
        end
      end

      S_ERASED: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.ev   = cfr_pkg::EV_ERASED;
          cmd_o.last = !done_q;
          state_d    = done_q ? S_DONE : S_IDLE;
        end
      end

      S_ACK: begin
        if (sts_i.out_free) begin
          cmd_o.push        = 1'b1;
          cmd_o.ev          = cfr_pkg::EV_ACK;
          cmd_o.last        = !done_q;
          cmd_o.begin_chunk = !done_q;
          state_d           = done_q ? S_DONE : S_IDLE;
        end
      end

      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.ev   = cfr_pkg::EV_DONE;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end

      // Walk the chunk buffer, one flash word per cycle while the result register is free
      S_WORD: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.ev   = cfr_pkg::EV_FLASH_WORD;
          cmd_o.last = sts_i.word_last;
          if (sts_i.word_last) begin
            state_d = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_IDLE;
      ev_q    <= cfr_pkg::EV_READY;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      ev_q    <= ev_d;
      done_q  <= done_d;
    end
  end

  // Checks
  a_word_in_flash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WORD) |-> (phase_q == PH_FLASH))
    else $error("flash words emitted outside the flash phase");

endmodule

// ----- rtl/core/chunked_firmware_receiver_crc32_top.sv -----
// An accepted transaction is decoded in the next cycle; its results are then registered
//   on the output one by one from the result states, each once the output is free.
// Throughput: a new transaction is taken after the last one's results are pushed;
//   a verified chunk emits ceil(length/4) buffered flash words, one per cycle unless stalled.
// Reset (async, active low): session idle, config registers to defaults (timeout 10000),
//   no pending result; the chunk buffer is not cleared.
module chunked_firmware_receiver_crc32_top (
  input  logic   clk_i,
  input  logic   rst_ni,
  cfr_item_if.sink     item_i,
  cfr_result_if.source result_o,
  cfr_cfg_if.sink      cfg_i
);

  cfr_pkg::dp_cmd_t dp_cmd;
  cfr_pkg::dp_sts_t dp_sts;
  logic             in_ready;

  assign item_i.ready = in_ready;

  cfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  cfr_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .command_i  (item_i.command),
    .rx_byte_i  (item_i.rx_byte),
    .flash_ok_i (item_i.flash_ok),
    .cfg_i      (cfg_i),
    .result_o   (result_o)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_REPORTS  = 10;

  // Session phases of the receiver, as tracked by the predictor
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SIZE  = 5'b00010,
    S_DATA  = 5'b00100,
    S_CRC   = 5'b01000,
    S_FLASH = 5'b10000
  } session_e;

  // One expected result transaction
  typedef struct {
    cfr_pkg::event_e ev;
    logic [31:0]     addr;
    logic [31:0]     word;
    logic [31:0]     size;
    logic            slot;
    logic            last;
  } fw_event_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cfr_item_if   item_if ();
  cfr_result_if res_if ();
  cfr_cfg_if    cfg_if ();

  chunked_firmware_receiver_crc32_top u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the configuration registers
  logic [31:0] cfg_target  = 32'h0;
  logic [31:0] cfg_slot_a  = 32'h0;
  logic [15:0] cfg_timeout = cfr_pkg::TIMEOUT_RST;

  // Predictor copy of the session state
  session_e    m_phase  = S_IDLE;
  logic [31:0] m_size   = '0;
  logic [1:0]  m_hdr    = '0;
  logic [31:0] m_done   = '0;
  logic [8:0]  m_len    = '0;
  logic [8:0]  m_fill   = '0;
  logic [31:0] m_crc    = cfr_pkg::CRC_INIT;
  logic [31:0] m_rx_crc = '0;
  logic [31:0] m_wptr   = '0;
  logic [15:0] m_ticks  = '0;
  logic [7:0]  m_buf [cfr_pkg::CHUNK_BYTES];

  fw_event_t pending_events [$];

  int err_cnt     = 0;
  int items_used  = 0;
  int burst_left  = 0;
  int hold_cycles = 0;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ cfr_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic fw_event_t make_event(cfr_pkg::event_e ev, logic [31:0] addr,
                                           logic [31:0] word, logic [31:0] size,
                                           logic slot);
    fw_event_t r;
    r.ev   = ev;
    r.addr = addr;
    r.word = word;
    r.size = size;
    r.slot = slot;
    r.last = 1'b0;
    return r;
  endfunction

  // Next chunk is min(CHUNK_BYTES, remaining) bytes
  function automatic void open_chunk();
    logic [31:0] rem;
    rem     = m_size - m_done;
    m_len   = (rem > 32'(cfr_pkg::CHUNK_BYTES)) ? cfr_pkg::CHUNK_LEN : rem[8:0];
    m_fill  = '0;
    m_crc   = cfr_pkg::CRC_INIT;
    m_ticks = '0;
    m_phase = S_DATA;
  endfunction

  // Advances the session model by one input transaction and queues the results.
  // Returns 0 when the transaction is ignored.
  function automatic bit predict_receiver(cfr_pkg::cmd_e cmd, logic [7:0] b, logic ok);
    fw_event_t   res [$];
    logic [31:0] w;
    logic [7:0]  v;
    bit          used;
    used = 1'b1;
    case (cmd)
      cfr_pkg::CMD_START: begin
        m_phase  = S_SIZE;
        m_size   = '0;
        m_hdr    = '0;
        m_done   = '0;
        m_len    = '0;
        m_fill   = '0;
        m_crc    = cfr_pkg::CRC_INIT;
        m_rx_crc = '0;
        m_wptr   = cfg_target;
        m_ticks  = '0;
        res.push_back(make_event(cfr_pkg::EV_READY, '0, '0, '0, 1'b0));
      end
      cfr_pkg::CMD_BYTE: begin
        case (m_phase)
          S_SIZE: begin
            m_size = m_size | (32'(b) << (8 * m_hdr));
            m_hdr  = m_hdr + 2'd1;
            if (m_hdr == 2'd0) begin
              res.push_back(make_event(cfr_pkg::EV_RECEIVING, '0, '0, m_size, 1'b0));
              res.push_back(make_event(cfr_pkg::EV_ERASE_REQ, '0, '0, '0,
                                       cfg_target != cfg_slot_a));
              res.push_back(make_event(cfr_pkg::EV_ERASED, '0, '0, '0, 1'b0));
              if (m_size == 32'h0) begin
                res.push_back(make_event(cfr_pkg::EV_DONE, '0, '0, '0, 1'b0));
                m_phase = S_IDLE;
              end else begin
                open_chunk();
              end
            end
          end
          S_DATA: begin
            m_buf[m_fill[7:0]] = b;
            m_crc  = crc32_byte(m_crc, b);
            m_fill = m_fill + 9'd1;
            if (m_fill >= m_len) begin
              m_phase  = S_CRC;
              m_hdr    = '0;
              m_rx_crc = '0;
              m_ticks  = '0;
            end
          end
          S_CRC: begin
            m_rx_crc = m_rx_crc | (32'(b) << (8 * m_hdr));
            m_hdr    = m_hdr + 2'd1;
            if (m_hdr == 2'd0) begin
              if (~m_crc != m_rx_crc) begin
                res.push_back(make_event(cfr_pkg::EV_NACK, '0, '0, '0, 1'b0));
                m_phase = S_IDLE;
              end else begin
                // little-endian words, 0xFF padding past the chunk end
                for (int i = 0; i < int'(m_len); i += 4) begin
                  w = '0;
                  for (int k = 0; k < 4; k++) begin
                    v = (i + k < int'(m_len)) ? m_buf[(i + k) % cfr_pkg::CHUNK_BYTES]
                                              : 8'hFF;
                    w[8*k +: 8] = v;
                  end
                  res.push_back(make_event(cfr_pkg::EV_FLASH_WORD, m_wptr + 32'(i), w,
                                           '0, 1'b0));
                end
                m_phase = S_FLASH;
              end
            end
          end
          default: used = 1'b0;
        endcase
      end
      cfr_pkg::CMD_TICK: begin
        if (m_phase inside {S_SIZE, S_DATA, S_CRC}) begin
          if (m_ticks != 16'hFFFF) m_ticks = m_ticks + 16'd1;
          if (m_ticks >= cfg_timeout) begin
            res.push_back(make_event((m_phase == S_SIZE) ? cfr_pkg::EV_SIZE_TIMEOUT :
                                     (m_phase == S_DATA) ? cfr_pkg::EV_CHUNK_TIMEOUT :
                                                           cfr_pkg::EV_CRC_TIMEOUT,
                                     '0, '0, '0, 1'b0));
            m_phase = S_IDLE;
          end
        end else begin
          used = 1'b0;
        end
      end
      default: begin
        if (m_phase == S_FLASH) begin
          if (!ok) begin
            res.push_back(make_event(cfr_pkg::EV_FLASH_FAIL, '0, '0, '0, 1'b0));
            m_phase = S_IDLE;
          end else begin
            m_wptr = m_wptr + 32'(m_len);
            m_done = m_done + 32'(m_len);
            res.push_back(make_event(cfr_pkg::EV_ACK, '0, '0, '0, 1'b0));
            if (m_done >= m_size) begin
              res.push_back(make_event(cfr_pkg::EV_DONE, '0, '0, '0, 1'b0));
              m_phase = S_IDLE;
            end else begin
              open_chunk();
            end
          end
        end else begin
          used = 1'b0;
        end
      end
    endcase
    if (res.size() != 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) pending_events.push_back(res[i]);
    return used;
  endfunction

  function automatic void note_error(string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  // Result checker: every accepted transaction against the oldest expectation
  always @(posedge clk_i) begin
    fw_event_t want;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (pending_events.size() == 0) begin
        note_error($sformatf("unexpected result ev=%0d addr=%h word=%h size=%h",
                             res_if.event_res, res_if.flash_address, res_if.flash_word,
                             res_if.image_size));
      end else begin
        want = pending_events.pop_front();
        if (res_if.event_res !== want.ev || res_if.flash_address !== want.addr ||
            res_if.flash_word !== want.word || res_if.image_size !== want.size ||
            res_if.erase_slot !== want.slot || res_if.last !== want.last) begin
          note_error($sformatf({"result mismatch: exp ev=%0d addr=%h word=%h size=%h ",
                                "slot=%0d last=%0d, got ev=%0d addr=%h word=%h size=%h ",
                                "slot=%0d last=%0d"},
                               want.ev, want.addr, want.word, want.size, want.slot,
                               want.last, res_if.event_res, res_if.flash_address,
                               res_if.flash_word, res_if.image_size, res_if.erase_slot,
                               res_if.last));
        end
      end
    end
  end

  // Result ready: random stall pattern, all-ready stretches, and long hold-offs on request
  initial begin
    logic [15:0] stall_pat;
    logic [3:0]  stall_pos;
    stall_pat    = '1;
    stall_pos    = '0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        res_if.ready <= 1'b0;
      end else begin
        if (stall_pos == 4'd0) begin
          stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
        end
        res_if.ready <= stall_pat[stall_pos];
        stall_pos = stall_pos + 4'd1;
      end
    end
  end

  // Offers one input transaction, in bursts with random gaps, and predicts it once taken
  task automatic send_item(cfr_pkg::cmd_e cmd, logic [7:0] b, logic ok);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        item_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    item_if.valid    <= 1'b1;
    item_if.command  <= cmd;
    item_if.rx_byte  <= b;
    item_if.flash_ok <= ok;
    do @(posedge clk_i); while (item_if.ready !== 1'b1);
    if (predict_receiver(cmd, b, ok)) items_used++;
  endtask

  // Waits for all expected results plus the pipeline depth
  task automatic settle();
    item_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [cfr_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    case (idx)
      cfr_pkg::REG_TARGET:  cfg_target  = val;
      cfr_pkg::REG_SLOT_A:  cfg_slot_a  = val;
      cfr_pkg::REG_TIMEOUT: cfg_timeout = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] target, logic [31:0] slot_a, logic [15:0] ticks);
    settle();
    cfg_write(cfr_pkg::REG_TARGET, target);
    cfg_write(cfr_pkg::REG_SLOT_A, slot_a);
    cfg_write(cfr_pkg::REG_TIMEOUT, {16'h0, ticks});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_size(logic [31:0] size);
    for (int j = 0; j < 4; j++) send_item(cfr_pkg::CMD_BYTE, size[8*j +: 8], 1'b0);
  endtask

  // Bytes and ticks with no session open are dropped
  task automatic test_idle_ignored();
    send_item(cfr_pkg::CMD_BYTE, 8'hFF, 1'b1);
    send_item(cfr_pkg::CMD_TICK, 8'h00, 1'b0);
    settle();
  endtask

  // Zero-length image: DONE right after ERASED
  task automatic test_empty_image();
    send_item(cfr_pkg::CMD_START, 8'h00, 1'b0);
    send_size(32'h0);
    settle();
  endtask

  // Five-byte image: second word padded, address wraps past the top
  task automatic test_partial_last_word();
    logic [7:0]  data [5] = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h3C};
    logic [31:0] crc_le;
    set_config(32'hFFFF_FFFC, 32'h0, 16'hFFFF);
    send_item(cfr_pkg::CMD_START, 8'h00, 1'b0);
    send_size(32'd5);
    foreach (data[i]) send_item(cfr_pkg::CMD_BYTE, data[i], 1'b0);
    crc_le = ~m_crc;
    send_size(crc_le);
    send_item(cfr_pkg::CMD_FLASH, 8'h00, 1'b1);
    settle();
  endtask

  // Shortest budget: size and chunk phases time out on the first tick
  task automatic test_timeouts();
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1);
    send_item(cfr_pkg::CMD_START, 8'h00, 1'b0);
    send_item(cfr_pkg::CMD_TICK, 8'h00, 1'b0);
    send_item(cfr_pkg::CMD_START, 8'h00, 1'b0);
    send_size(32'd1);
    send_item(cfr_pkg::CMD_TICK, 8'h00, 1'b0);
    send_item(cfr_pkg::CMD_FLASH, 8'h00, 1'b1);
    settle();
  endtask

  // Largest announced size; the session is abandoned by the next start
  task automatic test_max_size_abort();
    set_config(32'h0, 32'h0, 16'hFFFF);
    send_item(cfr_pkg::CMD_START, 8'h00, 1'b0);
    send_size(32'hFFFF_FFFF);
    settle();
  endtask

  // One session with random content, mostly well formed
  task automatic run_session(int tick_pct);
    logic [31:0] img_size;
    logic [31:0] crc_le;
    int          roll;
    roll   = $urandom_range(0, 99);
    crc_le = '0;
    if (roll < 8)       img_size = 32'h0;
    else if (roll < 16) img_size = $urandom;
    else if (roll < 30) img_size = $urandom_range(21, 64);
    else                img_size = $urandom_range(1, 20);
    send_item(cfr_pkg::CMD_START, 8'($urandom), 1'($urandom));
    while (m_phase != S_IDLE) begin
      if (m_phase == S_DATA && m_fill >= 9'd24 && img_size > 32'd64) break;
      roll = $urandom_range(0, 99);
      if (roll < tick_pct && m_phase != S_FLASH) begin
        send_item(cfr_pkg::CMD_TICK, 8'($urandom), 1'($urandom));
      end else if (roll < tick_pct + 3 && m_phase != S_FLASH) begin
        send_item(cfr_pkg::CMD_FLASH, 8'($urandom), 1'($urandom));
      end else if (roll >= 98) begin
        send_item(cfr_pkg::CMD_START, 8'($urandom), 1'($urandom));
        break;
      end else begin
        case (m_phase)
          S_SIZE: send_item(cfr_pkg::CMD_BYTE, img_size[8*m_hdr +: 8], 1'($urandom));
          S_DATA: begin
            send_item(cfr_pkg::CMD_BYTE, 8'($urandom), 1'($urandom));
            if (m_phase == S_CRC) begin
              crc_le = ~m_crc;
              if ($urandom_range(0, 9) == 0) crc_le[$urandom_range(0, 31)] ^= 1'b1;
            end
          end
          S_CRC: send_item(cfr_pkg::CMD_BYTE, crc_le[8*m_hdr +: 8], 1'($urandom));
          default: begin
            if ($urandom_range(0, 19) == 0) begin
              send_item(($urandom_range(0, 1) != 0) ? cfr_pkg::CMD_TICK : cfr_pkg::CMD_BYTE,
                        8'($urandom), 1'($urandom));
            end else begin
              send_item(cfr_pkg::CMD_FLASH, 8'($urandom), ($urandom_range(0, 7) != 0));
            end
          end
        endcase
      end
    end
  endtask

  task automatic test_random_traffic(logic [31:0] target, logic [31:0] slot_a,
                                     logic [15:0] ticks, int tick_pct, int n_items);
    int stop_at;
    set_config(target, slot_a, ticks);
    stop_at = items_used + n_items;
    while (items_used < stop_at) run_session(tick_pct);
  endtask

  // 16-byte chunk while the result side holds off: the block must stall its input
  task automatic test_output_backpressure();
    logic [31:0] crc_le;
    set_config(32'h0800_0000, 32'h0800_0000, 16'hFFFF);
    send_item(cfr_pkg::CMD_START, 8'h00, 1'b0);
    send_size(32'd16);
    repeat (16) send_item(cfr_pkg::CMD_BYTE, 8'($urandom), 1'b0);
    crc_le = ~m_crc;
    hold_cycles = 400;
    send_size(crc_le);
    send_item(cfr_pkg::CMD_FLASH, 8'h00, 1'b1);
    send_item(cfr_pkg::CMD_START, 8'h00, 1'b0);
    send_size(32'h0);
    settle();
  endtask

  initial begin
    rst_ni           = 1'b0;
    item_if.valid    = 1'b0;
    item_if.command  = cfr_pkg::CMD_START;
    item_if.rx_byte  = 8'h00;
    item_if.flash_ok = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = cfr_pkg::REG_TARGET;
    cfg_if.data      = 32'h0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_idle_ignored();
    test_empty_image();
    test_partial_last_word();
    test_timeouts();
    test_max_size_abort();
    test_random_traffic($urandom, cfg_target, 16'hFFFF, 10, 8);
    test_random_traffic(32'h1234_5678, 32'hEDCB_A987, 16'($urandom_range(2, 6)), 15, 8);
    test_random_traffic(32'hFFFF_FF00, 32'hFFFF_FF00, 16'd1, 3, 8);
    test_output_backpressure();
    settle();

    if (err_cnt == 0 && pending_events.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/cfr_pkg.sv
rtl/core/cfr_if.sv
rtl/core/cfr_ram.sv
rtl/core/cfr_dp.sv
rtl/core/cfr_ctrl.sv
rtl/core/chunked_firmware_receiver_crc32_top.sv
tb/sv/tb_top.sv
